// ----- rtl/ucfb_pkg.sv -----
// ----------------------------------------------------------------------------
// ucfb_pkg
// Shared types, register indexes and frame helpers for the UBX frame builder.
// ----------------------------------------------------------------------------
package ucfb_pkg;

	localparam int CNT_W = 5;

	// Operation codes of a request.
	localparam logic [1:0] OP_GET  = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_SYNC_FIRST      = 3'd0;
	localparam logic [2:0] REG_SYNC_SECOND     = 3'd1;
	localparam logic [2:0] REG_CONFIG_CLASS    = 3'd2;
	localparam logic [2:0] REG_GET_MESSAGE_ID  = 3'd3;
	localparam logic [2:0] REG_SET_MESSAGE_ID  = 3'd4;
	localparam logic [2:0] REG_PAYLOAD_VERSION = 3'd5;
	localparam logic [2:0] REG_GET_LAYER       = 3'd6;
	localparam logic [2:0] REG_SET_LAYER       = 3'd7;

	// Register reset values.
	localparam logic [7:0] RST_SYNC_FIRST      = 8'd181;
	localparam logic [7:0] RST_SYNC_SECOND     = 8'd98;
	localparam logic [7:0] RST_CONFIG_CLASS    = 8'd6;
	localparam logic [7:0] RST_GET_MESSAGE_ID  = 8'd139;
	localparam logic [7:0] RST_SET_MESSAGE_ID  = 8'd138;
	localparam logic [7:0] RST_PAYLOAD_VERSION = 8'd0;
	localparam logic [7:0] RST_GET_LAYER       = 8'd0;
	localparam logic [7:0] RST_SET_LAYER       = 8'd1;

	// Frame lengths in bytes.
	localparam logic [CNT_W-1:0] LEN_OVERHEAD = 5'd8;
	localparam logic [CNT_W-1:0] LEN_GET      = 5'd16;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] config_key;
		logic [63:0] set_value;
		logic [7:0]  poll_class;
		logic [7:0]  poll_id;
	} request_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} result_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] config_class;
		logic [7:0] get_message_id;
		logic [7:0] set_message_id;
		logic [7:0] payload_version;
		logic [7:0] get_layer;
		logic [7:0] set_layer;
	} cfg_regs_t;

	typedef struct packed {
		logic       clear;
		logic       accumulate;
		logic [7:0] data;
	} ck_ctrl_t;

	typedef struct packed {
		logic [7:0] cka;
		logic [7:0] ckb;
	} ck_sum_t;

	// Whole frame length for a request, checksum included.
	function automatic logic [CNT_W-1:0] frame_len(input logic [1:0] op,
			input logic [31:0] key);
		logic [CNT_W-1:0] len;
		len = LEN_GET;
		case (op)
			OP_POLL: len = LEN_OVERHEAD;
			OP_SET: begin
				case (key[30:28])
					3'd1, 3'd2: len = LEN_GET + 5'd1;
					3'd3:       len = LEN_GET + 5'd2;
					3'd4:       len = LEN_GET + 5'd4;
					default:    len = LEN_GET + 5'd8;
				endcase
			end
			default: len = LEN_GET;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/ubx_config_frame_builder.sv -----
// ----------------------------------------------------------------------------
// ubx_config_frame_builder
// Builds one UBX poll, value-get or value-set frame per request and sends it
// one byte per cycle, closing with a Fletcher-8 checksum.
// ----------------------------------------------------------------------------
// The sequencer latches a taken request, then registers each frame byte.
// Throughput: one byte per cycle; a frame (8, 16, 17, 18, 20 or 24 bytes)
// keeps busy high until its last byte is registered, and no new request is
// taken while busy; a byte counter walks the single checksum accumulator.
// Reset: arst_n clears the sequencer and loads the default frame constants.
// Results cannot be held off; each byte is on the ports for one cycle only.
// ----------------------------------------------------------------------------
module ubx_config_frame_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ucfb_pkg::request_t request,
	output logic               result_valid,
	output ucfb_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	ucfb_pkg::cfg_regs_t cfg_q;
	ucfb_pkg::ck_ctrl_t  ck_ctrl;
	ucfb_pkg::ck_sum_t   ck_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first      <= ucfb_pkg::RST_SYNC_FIRST;
			cfg_q.sync_second     <= ucfb_pkg::RST_SYNC_SECOND;
			cfg_q.config_class    <= ucfb_pkg::RST_CONFIG_CLASS;
			cfg_q.get_message_id  <= ucfb_pkg::RST_GET_MESSAGE_ID;
			cfg_q.set_message_id  <= ucfb_pkg::RST_SET_MESSAGE_ID;
			cfg_q.payload_version <= ucfb_pkg::RST_PAYLOAD_VERSION;
			cfg_q.get_layer       <= ucfb_pkg::RST_GET_LAYER;
			cfg_q.set_layer       <= ucfb_pkg::RST_SET_LAYER;
		end else if (cfg_we) begin
			case (cfg_index)
				ucfb_pkg::REG_SYNC_FIRST:      cfg_q.sync_first      <= cfg_data;
				ucfb_pkg::REG_SYNC_SECOND:     cfg_q.sync_second     <= cfg_data;
				ucfb_pkg::REG_CONFIG_CLASS:    cfg_q.config_class    <= cfg_data;
				ucfb_pkg::REG_GET_MESSAGE_ID:  cfg_q.get_message_id  <= cfg_data;
				ucfb_pkg::REG_SET_MESSAGE_ID:  cfg_q.set_message_id  <= cfg_data;
				ucfb_pkg::REG_PAYLOAD_VERSION: cfg_q.payload_version <= cfg_data;
				ucfb_pkg::REG_GET_LAYER:       cfg_q.get_layer       <= cfg_data;
				ucfb_pkg::REG_SET_LAYER:       cfg_q.set_layer       <= cfg_data;
				default: ;
			endcase
		end
	end

	ucfb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.cfg          (cfg_q),
		.sum          (ck_sum),
		.busy         (busy),
		.ck_ctrl      (ck_ctrl),
		.result_valid (result_valid),
		.result       (result)
	);

	ucfb_cksum u_cksum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ck_ctrl),
		.sum    (ck_sum)
	);

	// A byte is only ever produced by a frame that was in progress.
	a_valid_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a frame in progress");

	// The final checksum byte ends the transaction and frees the block.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_byte) |-> !busy)
		else $error("block still busy after the last byte");

	// The unused operation code produces no frame.
	a_none_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == ucfb_pkg::OP_NONE) |=> !busy)
		else $error("unused operation started a frame");

	// Checksum accumulation only happens while a frame is being sent.
	a_acc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ck_ctrl.accumulate |-> busy)
		else $error("checksum updated outside a frame");

endmodule

// ----- rtl/ucfb_cksum.sv -----
// ----------------------------------------------------------------------------
// ucfb_cksum
// Fletcher-8 accumulator, fed one frame byte per cycle by the sequencer.
// ----------------------------------------------------------------------------
module ucfb_cksum (
	input  logic               clk,
	input  logic               arst_n,
	input  ucfb_pkg::ck_ctrl_t ctrl,
	output ucfb_pkg::ck_sum_t  sum
);

	logic [7:0] cka_q;
	logic [7:0] ckb_q;
	logic [7:0] cka_next;

	assign cka_next = cka_q + ctrl.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cka_q <= 8'd0;
			ckb_q <= 8'd0;
		end else if (ctrl.clear) begin
			cka_q <= 8'd0;
			ckb_q <= 8'd0;
		end else if (ctrl.accumulate) begin
			cka_q <= cka_next;
			ckb_q <= ckb_q + cka_next;
		end
	end

	assign sum.cka = cka_q;
	assign sum.ckb = ckb_q;

endmodule

// ----- rtl/ucfb_seq.sv -----
// ----------------------------------------------------------------------------
// ucfb_seq
// Frame sequencer: steps a byte index through the frame, selects each byte
// and drives the checksum accumulator and the registered result.
// ----------------------------------------------------------------------------
module ucfb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ucfb_pkg::request_t  request,
	input  ucfb_pkg::cfg_regs_t cfg,
	input  ucfb_pkg::ck_sum_t   sum,
	output logic                busy,
	output ucfb_pkg::ck_ctrl_t  ck_ctrl,
	output logic                result_valid,
	output ucfb_pkg::result_t   result
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	// Byte positions inside a frame.
	localparam logic [ucfb_pkg::CNT_W-1:0] POS_CLASS   = 5'd2;
	localparam logic [ucfb_pkg::CNT_W-1:0] POS_KEY     = 5'd10;
	localparam logic [ucfb_pkg::CNT_W-1:0] POS_VALUE   = 5'd14;

	state_t                        state_q;
	ucfb_pkg::request_t            req_q;
	logic [ucfb_pkg::CNT_W-1:0]    idx_q;
	logic [ucfb_pkg::CNT_W-1:0]    total_q;
	logic                          result_valid_q;
	ucfb_pkg::result_t             result_q;

	logic                          accept;
	logic [ucfb_pkg::CNT_W-1:0]    last_idx;
	logic [ucfb_pkg::CNT_W-1:0]    cka_idx;
	logic [ucfb_pkg::CNT_W-1:0]    plen;
	logic [ucfb_pkg::CNT_W-1:0]    key_off;
	logic [ucfb_pkg::CNT_W-1:0]    val_off;
	logic                          is_poll;
	logic                          is_get;
	logic [7:0]                    byte_d;

	assign accept   = start && (state_q == S_IDLE);
	assign last_idx = total_q - 5'd1;
	assign cka_idx  = total_q - 5'd2;
	assign plen     = total_q - ucfb_pkg::LEN_OVERHEAD;
	assign key_off  = idx_q - POS_KEY;
	assign val_off  = idx_q - POS_VALUE;
	assign is_poll  = (req_q.operation == ucfb_pkg::OP_POLL);
	assign is_get   = (req_q.operation == ucfb_pkg::OP_GET);

	always_comb begin
		byte_d = 8'h00;
		if (idx_q == last_idx) begin
			byte_d = sum.ckb;
		end else if (idx_q == cka_idx) begin
			byte_d = sum.cka;
		end else begin
			case (idx_q)
				5'd0: byte_d = cfg.sync_first;
				5'd1: byte_d = cfg.sync_second;
				5'd2: byte_d = is_poll ? req_q.poll_class : cfg.config_class;
				5'd3: begin
					if (is_poll)
						byte_d = req_q.poll_id;
					else
						byte_d = is_get ? cfg.get_message_id : cfg.set_message_id;
				end
				5'd4: byte_d = {3'b000, plen};
				5'd6: byte_d = cfg.payload_version;
				5'd7: byte_d = is_get ? cfg.get_layer : cfg.set_layer;
				5'd10, 5'd11, 5'd12, 5'd13:
					byte_d = req_q.config_key[{key_off[1:0], 3'b000} +: 8];
				5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
					byte_d = req_q.set_value[{val_off[2:0], 3'b000} +: 8];
				default: byte_d = 8'h00;
			endcase
		end
	end

	// The checksum covers the class byte up to the end of the payload.
	assign ck_ctrl.clear      = accept;
	assign ck_ctrl.accumulate = (state_q == S_RUN) && (idx_q >= POS_CLASS)
		&& (idx_q < cka_idx);
	assign ck_ctrl.data       = byte_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			req_q          <= '0;
			idx_q          <= '0;
			total_q        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && request.operation != ucfb_pkg::OP_NONE) begin
						req_q   <= request;
						idx_q   <= '0;
						total_q <= ucfb_pkg::frame_len(request.operation,
							request.config_key);
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					result_valid_q      <= 1'b1;
					result_q.frame_byte <= byte_d;
					result_q.last_byte  <= (idx_q == last_idx);
					idx_q               <= idx_q + 5'd1;
					if (idx_q == last_idx)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q == S_RUN);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- tb/sv/ubx_config_frame_builder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubx_config_frame_builder_tb
// Self-checking bench for the UBX frame builder. A short table of directed
// requests runs first, then random requests under four register settings.
// Every byte that comes out is compared with a frame built here from the same
// request and the same register values, or typed in by hand for three polls.
// ----------------------------------------------------------------------------
module ubx_config_frame_builder_tb;

	localparam int GET_PAYLOAD_BYTES = 8;
	localparam int FRAME_OVERHEAD    = 8;
	localparam int SETTLE_CYCLES     = 6;
	localparam int REPORT_LIMIT      = 10;
	localparam int PHASE_ITEMS       = 32;
	localparam int DIR_ROWS          = 20;

	typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_NONE} row_check_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [63:0] value;
		logic [7:0]  pclass;
		logic [7:0]  pid;
		row_check_t  how;
		logic [63:0] frame;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	ucfb_pkg::request_t   request;
	logic                 result_valid;
	ucfb_pkg::result_t    result;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [7:0]           cfg_data;

	ucfb_pkg::cfg_regs_t  regs_model;
	ucfb_pkg::result_t    pending_bytes[$];
	dir_row_t             dir_rows [0:DIR_ROWS-1];

	int errors = 0;
	int bytes_checked = 0;
	int frames_checked = 0;
	int n_get = 0, n_set = 0, n_poll = 0, n_ignored = 0;

	ubx_config_frame_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void flag_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
	endfunction

	function automatic int value_bytes(logic [31:0] key);
		case (key[30:28])
			3'd1, 3'd2: return 1;
			3'd3:       return 2;
			3'd4:       return 4;
			default:    return 8;
		endcase
	endfunction

	// Fills every request field with random bits.
	function automatic ucfb_pkg::request_t random_bits();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return ucfb_pkg::request_t'(raw[$bits(ucfb_pkg::request_t)-1:0]);
	endfunction

	// Builds the whole frame for one request and queues its bytes.
	function automatic void predict_frame(ucfb_pkg::request_t r);
		logic [7:0]        fb [0:23];
		logic [7:0]        cka, ckb;
		ucfb_pkg::result_t rb;
		int                plen, total, n, i;
		if (r.operation == ucfb_pkg::OP_NONE)
			return;
		plen = 0;
		cka = '0;
		ckb = '0;
		fb[0] = regs_model.sync_first;
		fb[1] = regs_model.sync_second;
		if (r.operation == ucfb_pkg::OP_POLL) begin
			fb[2] = r.poll_class;
			fb[3] = r.poll_id;
		end else begin
			plen = GET_PAYLOAD_BYTES;
			fb[2] = regs_model.config_class;
			fb[3] = (r.operation == ucfb_pkg::OP_GET) ? regs_model.get_message_id
				: regs_model.set_message_id;
			fb[6] = regs_model.payload_version;
			fb[7] = (r.operation == ucfb_pkg::OP_GET) ? regs_model.get_layer
				: regs_model.set_layer;
			fb[8] = '0;
			fb[9] = '0;
			for (i = 0; i < 4; i++)
				fb[10 + i] = r.config_key[8 * i +: 8];
			if (r.operation == ucfb_pkg::OP_SET) begin
				n = value_bytes(r.config_key);
				for (i = 0; i < n; i++)
					fb[14 + i] = r.set_value[8 * i +: 8];
				plen += n;
			end
		end
		fb[4] = plen[7:0];
		fb[5] = '0;
		total = FRAME_OVERHEAD + plen;
		// Fletcher-8 runs from the class byte to the end of the payload.
		for (i = 2; i < total - 2; i++) begin
			cka = cka + fb[i];
			ckb = ckb + cka;
		end
		fb[total - 2] = cka;
		fb[total - 1] = ckb;
		for (i = 0; i < total; i++) begin
			rb.frame_byte = fb[i];
			rb.last_byte  = (i == total - 1);
			pending_bytes.push_back(rb);
		end
	endfunction

	// Queues a poll frame typed in by hand, first byte in the top bits.
	function automatic void push_typed(logic [63:0] frame);
		ucfb_pkg::result_t rb;
		int                i;
		for (i = 0; i < FRAME_OVERHEAD; i++) begin
			rb.frame_byte = frame[63 - 8 * i -: 8];
			rb.last_byte  = (i == FRAME_OVERHEAD - 1);
			pending_bytes.push_back(rb);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_bytes.size() == 0) begin
				flag_mismatch("unexpected byte", 8'h00, result.frame_byte);
			end else begin
				if (result.frame_byte !== pending_bytes[0].frame_byte)
					flag_mismatch("frame_byte", pending_bytes[0].frame_byte,
						result.frame_byte);
				if (result.last_byte !== pending_bytes[0].last_byte)
					flag_mismatch("last_byte", {7'd0, pending_bytes[0].last_byte},
						{7'd0, result.last_byte});
				if (pending_bytes[0].last_byte)
					frames_checked++;
				void'(pending_bytes.pop_front());
				bytes_checked++;
			end
		end
	end

	// Called just after a falling edge; returns after the first one past acceptance.
	task automatic issue(ucfb_pkg::request_t r, row_check_t how, logic [63:0] typed);
		start = 1'b1;
		request = r;
		do
			@(posedge clk);
		while (busy);
		case (how)
			CHECK_MODEL: predict_frame(r);
			CHECK_TYPED: push_typed(typed);
			default: ;
		endcase
		case (r.operation)
			ucfb_pkg::OP_GET:  n_get++;
			ucfb_pkg::OP_SET:  n_set++;
			ucfb_pkg::OP_POLL: n_poll++;
			default:           n_ignored++;
		endcase
		@(negedge clk);
	endtask

	task automatic idle_cycles(int n);
		start = 1'b0;
		request = random_bits();
		repeat (n) @(negedge clk);
	endtask

	// Lets every queued byte arrive, then waits out the settle period and any
	// frame still in progress before anything else is driven.
	task automatic wait_drained();
		start = 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] index, logic [7:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		case (index)
			ucfb_pkg::REG_SYNC_FIRST:      regs_model.sync_first = data;
			ucfb_pkg::REG_SYNC_SECOND:     regs_model.sync_second = data;
			ucfb_pkg::REG_CONFIG_CLASS:    regs_model.config_class = data;
			ucfb_pkg::REG_GET_MESSAGE_ID:  regs_model.get_message_id = data;
			ucfb_pkg::REG_SET_MESSAGE_ID:  regs_model.set_message_id = data;
			ucfb_pkg::REG_PAYLOAD_VERSION: regs_model.payload_version = data;
			ucfb_pkg::REG_GET_LAYER:       regs_model.get_layer = data;
			ucfb_pkg::REG_SET_LAYER:       regs_model.set_layer = data;
			default: ;
		endcase
	endtask

	task automatic load_settings(ucfb_pkg::cfg_regs_t s);
		wait_drained();
		write_reg(ucfb_pkg::REG_SYNC_FIRST, s.sync_first);
		write_reg(ucfb_pkg::REG_SYNC_SECOND, s.sync_second);
		write_reg(ucfb_pkg::REG_CONFIG_CLASS, s.config_class);
		write_reg(ucfb_pkg::REG_GET_MESSAGE_ID, s.get_message_id);
		write_reg(ucfb_pkg::REG_SET_MESSAGE_ID, s.set_message_id);
		write_reg(ucfb_pkg::REG_PAYLOAD_VERSION, s.payload_version);
		write_reg(ucfb_pkg::REG_GET_LAYER, s.get_layer);
		write_reg(ucfb_pkg::REG_SET_LAYER, s.set_layer);
		cfg_we = 1'b0;
	endtask

	function automatic ucfb_pkg::request_t random_request();
		ucfb_pkg::request_t r;
		int                 pick;
		r = random_bits();
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.operation = ucfb_pkg::OP_NONE;
		else if (pick < 30)
			r.operation = ucfb_pkg::OP_POLL;
		else if (pick < 55)
			r.operation = ucfb_pkg::OP_GET;
		else
			r.operation = ucfb_pkg::OP_SET;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			r.set_value = '0;
		else if (pick == 1)
			r.set_value = '1;
		return r;
	endfunction

	task automatic random_phase(bit quiet_sender, bit hold_once);
		int k;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			if (hold_once && k == PHASE_ITEMS / 2)
				wait_drained();
			if (!quiet_sender && $urandom_range(0, 99) < 15)
				idle_cycles($urandom_range(1, 25));
			issue(random_request(), CHECK_MODEL, '0);
		end
	endtask

	initial begin
		ucfb_pkg::request_t  r;
		ucfb_pkg::cfg_regs_t s;
		int                  k;

		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs_model = '{ucfb_pkg::RST_SYNC_FIRST, ucfb_pkg::RST_SYNC_SECOND,
			ucfb_pkg::RST_CONFIG_CLASS, ucfb_pkg::RST_GET_MESSAGE_ID,
			ucfb_pkg::RST_SET_MESSAGE_ID, ucfb_pkg::RST_PAYLOAD_VERSION,
			ucfb_pkg::RST_GET_LAYER, ucfb_pkg::RST_SET_LAYER};

		// Poll frames after reset can be read straight off the defaults.
		dir_rows[0]  = '{ucfb_pkg::OP_POLL, 32'h0, 64'h0, 8'h00, 8'h00, CHECK_TYPED,
			64'hB562_0000_0000_0000};
		dir_rows[1]  = '{ucfb_pkg::OP_POLL, 32'h0, 64'h0, 8'hFF, 8'hFF, CHECK_TYPED,
			64'hB562_FFFF_0000_FEF9};
		dir_rows[2]  = '{ucfb_pkg::OP_POLL, 32'h0, 64'h0, 8'h06, 8'h01, CHECK_TYPED,
			64'hB562_0601_0000_071B};
		dir_rows[3]  = '{ucfb_pkg::OP_NONE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			8'hFF, 8'hFF, CHECK_NONE, 64'h0};
		dir_rows[4]  = '{ucfb_pkg::OP_GET, 32'h0000_0000, 64'h0, 8'h00, 8'h00,
			CHECK_MODEL, 64'h0};
		dir_rows[5]  = '{ucfb_pkg::OP_GET, 32'hFFFF_FFFF, 64'h0, 8'h00, 8'h00,
			CHECK_MODEL, 64'h0};
		dir_rows[6]  = '{ucfb_pkg::OP_SET, 32'h0000_0000, 64'h0, 8'h00, 8'h00,
			CHECK_MODEL, 64'h0};
		dir_rows[7]  = '{ucfb_pkg::OP_SET, 32'h1000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[8]  = '{ucfb_pkg::OP_SET, 32'h2012_3456, 64'h0123_4567_89AB_CDEF,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[9]  = '{ucfb_pkg::OP_SET, 32'h3000_00A5, 64'hFEDC_BA98_7654_3210,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[10] = '{ucfb_pkg::OP_SET, 32'h40AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[11] = '{ucfb_pkg::OP_SET, 32'h5000_0100, 64'h1122_3344_5566_7788,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[12] = '{ucfb_pkg::OP_SET, 32'h6FFF_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[13] = '{ucfb_pkg::OP_SET, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[14] = '{ucfb_pkg::OP_SET, 32'h8000_0000, 64'h8000_0000_0000_0001,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		// Size code four with the top key bit set: the upper value bytes must not leak.
		dir_rows[15] = '{ucfb_pkg::OP_SET, 32'hC000_0000, 64'hFFFF_FFFF_0000_0000,
			8'h00, 8'h00, CHECK_MODEL, 64'h0};
		dir_rows[16] = '{ucfb_pkg::OP_GET, 32'h9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF,
			8'hFF, 8'hFF, CHECK_MODEL, 64'h0};
		dir_rows[17] = '{ucfb_pkg::OP_POLL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			8'h0A, 8'h04, CHECK_MODEL, 64'h0};
		dir_rows[18] = '{ucfb_pkg::OP_NONE, 32'h0, 64'h0, 8'h00, 8'h00, CHECK_NONE,
			64'h0};
		dir_rows[19] = '{ucfb_pkg::OP_GET, 32'h1234_5678, 64'h0, 8'h00, 8'h00,
			CHECK_MODEL, 64'h0};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			r = '0;
			r.operation  = dir_rows[k].op;
			r.config_key = dir_rows[k].key;
			r.set_value  = dir_rows[k].value;
			r.poll_class = dir_rows[k].pclass;
			r.poll_id    = dir_rows[k].pid;
			issue(r, dir_rows[k].how, dir_rows[k].frame);
		end

		load_settings('0);
		random_phase(1'b0, 1'b0);

		// This phase sends back to back, with no gaps from the sender.
		load_settings('1);
		random_phase(1'b1, 1'b0);

		s = ucfb_pkg::cfg_regs_t'({$urandom, $urandom});
		load_settings(s);
		random_phase(1'b0, 1'b1);

		s = '{ucfb_pkg::RST_SYNC_FIRST, ucfb_pkg::RST_SYNC_SECOND,
			ucfb_pkg::RST_CONFIG_CLASS, ucfb_pkg::RST_GET_MESSAGE_ID,
			ucfb_pkg::RST_SET_MESSAGE_ID, ucfb_pkg::RST_PAYLOAD_VERSION,
			ucfb_pkg::RST_GET_LAYER, ucfb_pkg::RST_SET_LAYER};
		load_settings(s);
		random_phase(1'b0, 1'b0);

		start = 1'b0;
		for (k = 0; k < 2000 && pending_bytes.size() != 0; k++)
			@(negedge clk);
		if (pending_bytes.size() != 0) begin
			$display("%0d expected bytes never arrived", pending_bytes.size());
			errors += pending_bytes.size();
		end
		repeat (SETTLE_CYCLES * 4) @(negedge clk);

		$display("Requests taken: %0d value-get, %0d value-set, %0d poll, %0d ignored,",
			n_get, n_set, n_poll, n_ignored);
		$display("under four register settings; %0d frames and %0d bytes compared.",
			frames_checked, bytes_checked);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches in total", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ucfb_pkg.sv
rtl/ucfb_cksum.sv
rtl/ucfb_seq.sv
rtl/ubx_config_frame_builder.sv
tb/sv/ubx_config_frame_builder_tb.sv
